@@ hdl/mbf_pkg.sv @@
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared types and codes for the faulting byte-addressed memory bus.
// ----------------------------------------------------------------------------
package mbf_pkg;

    // action codes
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    // access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_LOAD  = 2'd1;
    localparam logic [1:0] FAULT_STORE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MEM_BASE = 3'd0;
    localparam logic [2:0] CFG_MEM_SIZE = 3'd1;
    localparam logic [2:0] CFG_RAM_BASE = 3'd2;
    localparam logic [2:0] CFG_RAM_SIZE = 3'd3;
    localparam logic [2:0] CFG_IO_BASE  = 3'd4;

    // reset values of the configuration registers
    localparam logic [31:0] RST_MEM_BASE = 32'h0000_0000;
    localparam logic [16:0] RST_MEM_SIZE = 17'h1_0000;
    localparam logic [31:0] RST_RAM_BASE = 32'h0000_0000;
    localparam logic [16:0] RST_RAM_SIZE = 17'h1_0000;
    localparam logic [31:0] RST_IO_BASE  = 32'h8000_0000;

    // widest store index carried between front and back (16M bytes)
    localparam int SLOT_W = 24;

    // entries in the queue between front and back
    localparam int Q_DEPTH = 2;

    // what the back end does with a transaction
    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE
    } t_op;

    // back end sequencer states
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ACCESS,
        BS_FINISH
    } t_bstate;

    // configuration registers as seen by the front end
    typedef struct packed {
        logic [31:0] mem_base;
        logic [16:0] mem_size;
        logic [31:0] ram_base;
        logic [16:0] ram_size;
        logic [31:0] io_base;
    } t_cfg;

    // classified transaction handed from front to back
    typedef struct packed {
        t_op               op;
        logic [1:0]        last;   // bytes to move minus one
        logic [1:0]        wrap_k; // byte whose offset passes 2^32, zero if none
        logic [SLOT_W-1:0] slot;   // store index of the first byte
        logic [31:0]       wdata;
        logic [31:0]       rdata;  // result when nothing is read
        logic [1:0]        fault;
    } t_entry;

endpackage

@@ hdl/mbf_ram.sv @@
// ----------------------------------------------------------------------------
// mbf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one access per cycle, read data available in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ hdl/mbf_front.sv @@
// ----------------------------------------------------------------------------
// mbf_front
// Accepts transactions, range-checks them and reduces the store index.
// ----------------------------------------------------------------------------
module mbf_front #(
    parameter int MEM_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbf_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_action,
    input  logic [1:0]     i_access_size,
    input  logic [31:0]    i_address,
    input  logic [31:0]    i_write_data,
    output logic           o_push,
    output mbf_pkg::t_entry o_entry,
    input  logic           i_q_full
);
    import mbf_pkg::*;

    localparam int  AW            = $clog2(MEM_BYTES);
    localparam bit  IS_POW2       = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
    localparam int  BITS_PER_STEP = 4;
    localparam int  RED_STEPS     = 32 / BITS_PER_STEP;
    localparam int  CNT_W         = $clog2(RED_STEPS + 1);
    localparam logic [AW:0] MOD   = (AW + 1)'(MEM_BYTES);

    logic             r_busy;
    logic [CNT_W-1:0] r_steps;
    logic [31:0]      r_x;
    logic [AW-1:0]    r_rem;
    logic [1:0]       r_action;
    logic [1:0]       r_size;
    logic [31:0]      r_addr;
    logic [31:0]      r_wdata;

    logic             accept;
    logic             done;
    logic [AW-1:0]    n_rem;
    logic [AW-1:0]    slot;
    logic [2:0]       nbytes;
    logic             size_ok;
    logic [31:0]      addr_off;
    logic             mem_ok;
    logic             ram_ok;
    t_entry           entry;

    // handshake
    assign done       = (r_steps == '0);
    assign o_push     = r_busy && done && !i_q_full;
    assign o_in_stall = r_busy && !o_push;
    assign accept     = i_in_valid && !o_in_stall;

    // remainder by the store depth, a few bits per cycle from the top
    always_comb begin
        logic [AW:0]   trial;
        logic [AW-1:0] rem_t;
        rem_t = r_rem;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            trial = {rem_t, r_x[31-j]};
            if (trial >= MOD) begin
                trial = trial - MOD;
            end
            rem_t = trial[AW-1:0];
        end
        n_rem = rem_t;
    end

    assign slot = IS_POW2 ? r_x[AW-1:0] : r_rem;

    // item registers and reduction sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_steps <= IS_POW2 ? '0 : CNT_W'(RED_STEPS);
        end else if (o_push) begin
            r_busy  <= 1'b0;
        end else if (!done) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_size   <= i_access_size;
            r_addr   <= i_address;
            r_wdata  <= i_write_data;
            r_rem    <= '0;
            r_x      <= (i_action == ACT_PRELOAD) ? i_address : i_address - i_cfg.mem_base;
        end else if (!done) begin
            r_rem    <= n_rem;
            r_x      <= {r_x[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
        end
    end

    // range checks with 33-bit region ends
    always_comb begin
        case (r_size)
            SZ_BYTE: nbytes = 3'd1;
            SZ_HALF: nbytes = 3'd2;
            default: nbytes = 3'd4;
        endcase
    end

    assign size_ok = (r_size == SZ_BYTE) || (r_size == SZ_HALF) || (r_size == SZ_WORD);

    // offset from the memory base, wraps at 2^32
    assign addr_off = r_addr - i_cfg.mem_base;

    assign mem_ok = (r_addr >= i_cfg.mem_base) &&
                    ({1'b0, r_addr} + 33'(nbytes) <= {1'b0, i_cfg.mem_base} + 33'(i_cfg.mem_size));
    assign ram_ok = (r_addr >= i_cfg.ram_base) &&
                    ({1'b0, r_addr} + 33'(nbytes) <= {1'b0, i_cfg.ram_base} + 33'(i_cfg.ram_size));

    // classification
    always_comb begin
        entry.op     = OP_NONE;
        entry.last   = 2'(nbytes - 3'd1);
        entry.wrap_k = (&addr_off[31:2]) ? 2'd0 - addr_off[1:0] : 2'd0;
        entry.slot   = SLOT_W'(slot);
        entry.wdata  = r_wdata;
        entry.rdata  = '0;
        entry.fault  = FAULT_NONE;
        case (r_action)
            ACT_READ: begin
                if (size_ok && mem_ok) begin
                    entry.op = OP_READ;
                end else if (r_size == SZ_BYTE && r_addr == i_cfg.io_base) begin
                    entry.rdata = 32'h0000_00ff;
                end else begin
                    entry.fault = FAULT_LOAD;
                    case (r_size)
                        SZ_BYTE: entry.rdata = 32'h0000_00ff;
                        SZ_HALF: entry.rdata = 32'h0000_ffff;
                        default: entry.rdata = 32'hffff_ffff;
                    endcase
                end
            end
            ACT_WRITE: begin
                if (size_ok && ram_ok) begin
                    entry.op = OP_WRITE;
                end else if (r_size == SZ_BYTE && r_addr == i_cfg.io_base + 32'd1) begin
                    // terminal data write, dropped
                    entry.op = OP_NONE;
                end else begin
                    entry.fault = FAULT_STORE;
                end
            end
            ACT_PRELOAD: begin
                entry.op     = OP_WRITE;
                entry.last   = 2'd0;
                entry.wrap_k = 2'd0;
            end
            default: begin
                entry.op = OP_NONE;
            end
        endcase
    end

    assign o_entry = entry;

    // reduction only runs while an item is held
    a_steps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps != '0) |-> r_busy)
        else $error("front reduction running with no item held");

endmodule

@@ hdl/mbf_queue.sv @@
// ----------------------------------------------------------------------------
// mbf_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mbf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output mbf_pkg::t_entry o_entry,
    output logic            o_empty
);
    import mbf_pkg::*;

    localparam int QA = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_entry          r_mem [Q_DEPTH];
    logic [QA-1:0]   r_wp;
    logic [QA-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

endmodule

@@ hdl/mbf_back.sv @@
// ----------------------------------------------------------------------------
// mbf_back
// Carries out queued transactions one byte per cycle and holds the result.
// ----------------------------------------------------------------------------
module mbf_back #(
    parameter int MEM_BYTES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbf_pkg::t_entry i_q_entry,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_read_data,
    output logic [1:0]      o_fault
);
    import mbf_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MEM_BYTES - 1);

    t_bstate       r_state;
    t_bstate       n_state;
    t_entry        r_ent;
    logic [1:0]    r_k;
    logic [AW-1:0] r_slot;
    logic [31:0]   r_acc;
    logic          r_pend;
    logic [1:0]    r_pend_lane;
    logic          r_o_valid;
    logic [31:0]   r_o_data;
    logic [1:0]    r_o_fault;

    logic          out_free;
    logic          pop;
    logic          load_out;
    logic          ram_we;
    logic          issue_read;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_q;
    logic [31:0]   merged;
    t_bstate       pop_state;

    assign out_free  = !r_o_valid || !i_out_stall;
    assign pop_state = (i_q_entry.op == OP_NONE) ? BS_FINISH : BS_ACCESS;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    n_state = pop_state;
                end
            end
            BS_ACCESS: begin
                if (r_k == r_ent.last) begin
                    n_state = BS_FINISH;
                end
            end
            BS_FINISH: begin
                if (out_free) begin
                    n_state = i_q_empty ? BS_IDLE : pop_state;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        pop        = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        issue_read = 1'b0;
        case (r_state)
            BS_IDLE: begin
                pop = !i_q_empty;
            end
            BS_ACCESS: begin
                ram_we     = (r_ent.op == OP_WRITE);
                issue_read = (r_ent.op == OP_READ);
            end
            BS_FINISH: begin
                load_out = out_free;
                pop      = out_free && !i_q_empty;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_q_pop   = pop;
    assign ram_wdata = r_ent.wdata[{r_k, 3'b000} +: 8];

    // byte store
    mbf_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_slot),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // fold in the byte read last cycle
    always_comb begin
        merged = r_acc;
        if (r_pend) begin
            merged[{r_pend_lane, 3'b000} +: 8] = ram_q;
        end
    end

    // state and pending read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue_read;
        end
    end

    // working transaction; the store index restarts at zero where the offset passes 2^32
    always_ff @(posedge i_clk) begin
        r_pend_lane <= r_k;
        if (pop) begin
            r_ent  <= i_q_entry;
            r_k    <= 2'd0;
            r_slot <= i_q_entry.slot[AW-1:0];
            r_acc  <= i_q_entry.rdata;
        end else begin
            r_acc <= merged;
            if (r_state == BS_ACCESS) begin
                r_k    <= r_k + 2'd1;
                r_slot <= (r_slot == LAST_SLOT || (r_k + 2'd1) == r_ent.wrap_k) ?
                          '0 : r_slot + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_data  <= merged;
            r_o_fault <= r_ent.fault;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_read_data = r_o_data;
    assign o_fault     = r_o_fault;

    a_access_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_ACCESS) |-> (r_ent.op != OP_NONE))
        else $error("memory access sequenced for a transaction without one");

    a_pend_from_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == BS_ACCESS))
        else $error("read data pending without a read issued");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_o_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

endmodule

@@ hdl/memory_bus_with_access_faults_unit.sv @@
// path: the front end holds each accepted transaction, reducing its store index 4 bits
//   per cycle when MEM_BYTES is not a power of two, and pushes it into the queue; the
//   back end moves its bytes through the byte store and loads the result register
// throughput: one transaction per cycle when no bytes move, no stall holds the flow
//   and MEM_BYTES is a power of two; the byte store works on one transaction at a time
// reset: control and config registers cleared to defaults, byte store not cleared
// ----------------------------------------------------------------------------
// memory_bus_with_access_faults_unit
// Byte-addressed little-endian memory with load and store fault reporting.
// ----------------------------------------------------------------------------
module memory_bus_with_access_faults_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_fault
);
    import mbf_pkg::*;

    logic [31:0] r_mem_base;
    logic [16:0] r_mem_size;
    logic [31:0] r_ram_base;
    logic [16:0] r_ram_size;
    logic [31:0] r_io_base;

    t_cfg   cfg;
    logic   push;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    t_entry push_entry;
    t_entry pop_entry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= RST_MEM_BASE;
            r_mem_size <= RST_MEM_SIZE;
            r_ram_base <= RST_RAM_BASE;
            r_ram_size <= RST_RAM_SIZE;
            r_io_base  <= RST_IO_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEM_BASE: r_mem_base <= i_cfg_wdata;
                CFG_MEM_SIZE: r_mem_size <= i_cfg_wdata[16:0];
                CFG_RAM_BASE: r_ram_base <= i_cfg_wdata;
                CFG_RAM_SIZE: r_ram_size <= i_cfg_wdata[16:0];
                CFG_IO_BASE:  r_io_base  <= i_cfg_wdata;
                default:      r_io_base  <= r_io_base;
            endcase
        end
    end

    assign cfg.mem_base = r_mem_base;
    assign cfg.mem_size = r_mem_size;
    assign cfg.ram_base = r_ram_base;
    assign cfg.ram_size = r_ram_size;
    assign cfg.io_base  = r_io_base;

    // accept and classify
    mbf_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_access_size (i_access_size),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_q_full      (q_full)
    );

    // decoupling queue
    mbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_empty (q_empty)
    );

    // execute against the byte store
    mbf_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_entry   (pop_entry),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_fault     (o_fault)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the faulting byte-addressed memory bus. A local
// predictor keeps its own byte image and region settings, computes the data
// and fault code of every accepted transaction, and a checker compares each
// result in order. Directed cases cover region ends, the terminal addresses,
// unknown sizes and actions and empty regions; random traffic runs under
// several configurations with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;
    import mbf_pkg::*;

    localparam int          MEM_BYTES   = 65536;
    localparam logic [1:0]  ACT_IGNORED = 2'd3;
    localparam logic [1:0]  SZ_UNKNOWN  = 2'd3;

    typedef struct {
        logic [31:0] read_data;
        logic [1:0]  fault;
    } bus_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [1:0]  i_access_size;
    logic [31:0] i_address;
    logic [31:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_read_data;
    logic [1:0]  o_fault;

    // predictor state: byte image, which bytes hold known data, region setup
    logic [7:0]  image_bytes [MEM_BYTES];
    bit          image_known [MEM_BYTES];
    logic [31:0] cfg_mem_base = RST_MEM_BASE;
    logic [16:0] cfg_mem_size = RST_MEM_SIZE;
    logic [31:0] cfg_ram_base = RST_RAM_BASE;
    logic [16:0] cfg_ram_size = RST_RAM_SIZE;
    logic [31:0] cfg_io_base  = RST_IO_BASE;

    bus_result_t pending_responses [$];
    bit          no_idle = 1'b0;
    int          n_errors = 0;
    int          n_reads = 0;
    int          n_writes = 0;
    int          n_preloads = 0;
    int          n_other = 0;
    int          n_load_faults = 0;
    int          n_store_faults = 0;
    int          n_configs = 0;

    memory_bus_with_access_faults_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_access_size (i_access_size),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_fault       (o_fault)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // byte range check with 33-bit ends, so a region never wraps
    function automatic bit in_region(logic [31:0] addr, int unsigned nbytes,
                                     logic [31:0] base, logic [16:0] size);
        logic [32:0] last_end;
        logic [32:0] region_end;
        last_end   = {1'b0, addr} + 33'(nbytes);
        region_end = {1'b0, base} + {16'd0, size};
        return (addr >= base) && (last_end <= region_end);
    endfunction

    function automatic int unsigned slot_of(logic [31:0] offset);
        return offset % 32'(MEM_BYTES);
    endfunction

    function automatic int unsigned width_bytes(logic [1:0] sz);
        return (sz == SZ_BYTE) ? 1 : (sz == SZ_HALF) ? 2 : 4;
    endfunction

    // expected data and fault of one transaction; updates the byte image
    function automatic void predict_access(input logic [1:0] act, input logic [1:0] sz,
                                           input logic [31:0] addr, input logic [31:0] data,
                                           output logic [31:0] rd, output logic [1:0] flt);
        int unsigned nbytes;
        logic [31:0] offset;
        int unsigned k;
        int unsigned s;
        rd     = 32'd0;
        flt    = FAULT_NONE;
        nbytes = width_bytes(sz);
        offset = addr - cfg_mem_base;
        case (act)
            ACT_READ: begin
                if (sz != SZ_UNKNOWN && in_region(addr, nbytes, cfg_mem_base, cfg_mem_size)) begin
                    for (k = 0; k < nbytes; k++) begin
                        rd[8*k +: 8] = image_bytes[slot_of(offset + k)];
                    end
                end else if (sz == SZ_BYTE && addr == cfg_io_base) begin
                    rd = 32'h0000_00ff;
                end else begin
                    flt = FAULT_LOAD;
                    rd  = (sz == SZ_BYTE) ? 32'h0000_00ff :
                          (sz == SZ_HALF) ? 32'h0000_ffff : 32'hffff_ffff;
                end
            end
            ACT_WRITE: begin
                if (sz != SZ_UNKNOWN && in_region(addr, nbytes, cfg_ram_base, cfg_ram_size)) begin
                    for (k = 0; k < nbytes; k++) begin
                        s = slot_of(offset + k);
                        image_bytes[s] = data[8*k +: 8];
                        image_known[s] = 1'b1;
                    end
                end else if (!(sz == SZ_BYTE && addr == cfg_io_base + 32'd1)) begin
                    // anything but a terminal data byte faults
                    flt = FAULT_STORE;
                end
            end
            ACT_PRELOAD: begin
                s = slot_of(addr);
                image_bytes[s] = data[7:0];
                image_known[s] = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result-side stall pattern
    initial begin
        int run;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (no_idle) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = pick_gap();
                if (run > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (run) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        bus_result_t want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_responses.size() == 0) begin
                $error("result transaction with none expected: read_data %h fault %0d",
                       o_read_data, o_fault);
                n_errors++;
            end else begin
                want = pending_responses.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %h, actual %h",
                           want.read_data, o_read_data);
                    n_errors++;
                end
                if (o_fault !== want.fault) begin
                    $error("fault mismatch: expected %0d, actual %0d", want.fault, o_fault);
                    n_errors++;
                end
            end
        end
    end

    // send one transaction, record its expected result at acceptance
    task automatic send_txn(input logic [1:0] act, input logic [1:0] sz,
                            input logic [31:0] addr, input logic [31:0] data);
        bus_result_t r;
        int gap;
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_access_size <= sz;
        i_address     <= addr;
        i_write_data  <= data;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_access(act, sz, addr, data, r.read_data, r.fault);
        pending_responses.push_back(r);
        case (act)
            ACT_READ:    n_reads++;
            ACT_WRITE:   n_writes++;
            ACT_PRELOAD: n_preloads++;
            default:     n_other++;
        endcase
        if (r.fault == FAULT_LOAD) n_load_faults++;
        if (r.fault == FAULT_STORE) n_store_faults++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding transaction complete
    task automatic wait_bus_idle();
        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write all five region registers back to back; size writes may carry junk
    task automatic set_config(input logic [31:0] mb, input logic [16:0] msz,
                              input logic [31:0] rb, input logic [16:0] rsz,
                              input logic [31:0] io);
        logic [31:0] vals [5];
        logic [2:0]  idxs [5];
        int k;
        idxs[0] = CFG_MEM_BASE;
        idxs[1] = CFG_MEM_SIZE;
        idxs[2] = CFG_RAM_BASE;
        idxs[3] = CFG_RAM_SIZE;
        idxs[4] = CFG_IO_BASE;
        vals[0] = mb;
        vals[1] = {($urandom_range(0, 1) ? 15'($urandom) : 15'd0), msz};
        vals[2] = rb;
        vals[3] = {($urandom_range(0, 1) ? 15'($urandom) : 15'd0), rsz};
        vals[4] = io;
        for (k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        cfg_mem_base = mb;
        cfg_mem_size = msz;
        cfg_ram_base = rb;
        cfg_ram_size = rsz;
        cfg_io_base  = io;
        n_configs++;
    endtask

    // preload any byte a successful read would touch that holds no known data
    task automatic fill_before_read(input logic [1:0] sz, input logic [31:0] addr);
        int unsigned nbytes;
        int unsigned k;
        int unsigned s;
        nbytes = width_bytes(sz);
        if (sz != SZ_UNKNOWN && in_region(addr, nbytes, cfg_mem_base, cfg_mem_size)) begin
            for (k = 0; k < nbytes; k++) begin
                s = slot_of(addr - cfg_mem_base + k);
                if (!image_known[s]) begin
                    send_txn(ACT_PRELOAD, 2'($urandom), {16'($urandom), 16'(s)}, $urandom);
                end
            end
        end
    endtask

    // address near the interesting points of the current setup
    function automatic logic [31:0] pick_address(logic [1:0] act);
        int r;
        logic [31:0] a;
        r = $urandom_range(0, 99);
        if (act == ACT_PRELOAD) begin
            if (r < 40)      a = $urandom_range(0, 63);
            else if (r < 60) a = cfg_ram_base - cfg_mem_base + $urandom_range(0, 63);
            else if (r < 75) a = 32'(cfg_mem_size) - 8 + $urandom_range(0, 7);
            else             a = $urandom;
            // the store index ignores bits above the store size
            if ($urandom_range(0, 1)) a[31:16] = 16'($urandom);
            return a;
        end
        if (r < 30) return cfg_mem_base + $urandom_range(0, 63);
        if (r < 45) return cfg_ram_base + $urandom_range(0, 63);
        if (r < 55) return cfg_mem_base + 32'(cfg_mem_size) - 4 + $urandom_range(0, 7);
        if (r < 65) return cfg_ram_base + 32'(cfg_ram_size) - 4 + $urandom_range(0, 7);
        if (r < 75) return cfg_io_base + $urandom_range(0, 1);
        if (r < 80) return cfg_mem_base - $urandom_range(1, 4);
        return $urandom;
    endfunction

    task automatic random_burst(input int count);
        int i;
        int r;
        logic [1:0]  act;
        logic [1:0]  sz;
        logic [31:0] addr;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            act = (r < 45) ? ACT_READ : (r < 80) ? ACT_WRITE :
                  (r < 95) ? ACT_PRELOAD : ACT_IGNORED;
            sz = ($urandom_range(0, 99) < 4) ? SZ_UNKNOWN : 2'($urandom_range(0, 2));
            addr = pick_address(act);
            if (act == ACT_READ) fill_before_read(sz, addr);
            send_txn(act, sz, addr, $urandom);
        end
    endtask

    // random region setup, RAM placed inside the memory region
    task automatic random_config();
        logic [16:0] msz;
        logic [16:0] rsz;
        logic [31:0] mb;
        logic [31:0] io;
        int unsigned off;
        int r;
        r = $urandom_range(0, 9);
        msz = (r < 4) ? 17'h1_0000 : (r < 7) ? 17'($urandom_range(1, 65536)) :
              (r < 9) ? 17'($urandom_range(1, 16)) : 17'd0;
        case ($urandom_range(0, 4))
            0:       mb = 32'h0000_0000;
            1:       mb = 32'hffff_ffff - 32'(msz) + 32'd1;
            2:       mb = 32'hffff_ffff;
            default: mb = $urandom;
        endcase
        off = $urandom_range(0, msz);
        rsz = 17'($urandom_range(0, msz - off));
        case ($urandom_range(0, 4))
            0:       io = mb + 32'(msz);
            1:       io = mb;
            2:       io = 32'hffff_ffff;
            3:       io = 32'h0000_0000;
            default: io = $urandom;
        endcase
        set_config(mb, msz, mb + off, rsz, io);
    endtask

    // reset setup: region ends, terminal, unknown size and action
    task automatic test_reset_defaults();
        send_txn(ACT_WRITE,   SZ_WORD,    32'h0000_0000, 32'h4433_2211);
        send_txn(ACT_READ,    SZ_BYTE,    32'h0000_0000, 32'h0);
        send_txn(ACT_READ,    SZ_HALF,    32'h0000_0001, 32'h0);
        send_txn(ACT_READ,    SZ_WORD,    32'h0000_0000, 32'h0);
        send_txn(ACT_WRITE,   SZ_HALF,    32'h0000_fffe, 32'hbeef_cafe);
        send_txn(ACT_PRELOAD, SZ_BYTE,    32'hffff_fffc, 32'h0000_005a);
        send_txn(ACT_PRELOAD, SZ_WORD,    32'h0001_fffd, 32'hffff_ffc3);
        send_txn(ACT_READ,    SZ_WORD,    32'h0000_fffc, 32'h0);
        send_txn(ACT_READ,    SZ_WORD,    32'h0000_fffd, 32'h0);
        send_txn(ACT_READ,    SZ_HALF,    32'h0000_ffff, 32'h0);
        send_txn(ACT_READ,    SZ_BYTE,    32'h0001_0000, 32'h0);
        send_txn(ACT_WRITE,   SZ_WORD,    32'h0000_fffd, 32'h1234_5678);
        send_txn(ACT_READ,    SZ_BYTE,    RST_IO_BASE, 32'h0);
        send_txn(ACT_READ,    SZ_HALF,    RST_IO_BASE, 32'h0);
        send_txn(ACT_READ,    SZ_BYTE,    RST_IO_BASE + 32'd1, 32'h0);
        send_txn(ACT_WRITE,   SZ_BYTE,    RST_IO_BASE + 32'd1, 32'h0000_0041);
        send_txn(ACT_WRITE,   SZ_WORD,    RST_IO_BASE + 32'd1, 32'h0000_0041);
        send_txn(ACT_WRITE,   SZ_BYTE,    RST_IO_BASE, 32'h0000_0041);
        send_txn(ACT_READ,    SZ_UNKNOWN, 32'h0000_0000, 32'h0);
        send_txn(ACT_WRITE,   SZ_UNKNOWN, 32'h0000_0000, 32'hdead_beef);
        send_txn(ACT_IGNORED, SZ_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
        send_txn(ACT_WRITE,   SZ_WORD,    32'hffff_ffff, 32'hffff_ffff);
        send_txn(ACT_READ,    SZ_WORD,    32'hffff_fffc, 32'h0);
        send_txn(ACT_WRITE,   SZ_BYTE,    32'h0000_0000, 32'hffff_ffa5);
        send_txn(ACT_READ,    SZ_WORD,    32'h0000_0000, 32'h0);
    endtask

    // regions ending exactly at the top of the address space
    task automatic test_top_of_address_space();
        wait_bus_idle();
        set_config(32'hffff_0000, 17'h1_0000, 32'hffff_8000, 17'h0_8000, 32'hffff_ffff);
        send_txn(ACT_WRITE, SZ_WORD, 32'hffff_fffc, 32'h8765_4321);
        send_txn(ACT_READ,  SZ_WORD, 32'hffff_fffc, 32'h0);
        send_txn(ACT_READ,  SZ_BYTE, 32'hffff_ffff, 32'h0);
        send_txn(ACT_READ,  SZ_WORD, 32'hffff_fffe, 32'h0);
        send_txn(ACT_WRITE, SZ_BYTE, 32'h0000_0000, 32'h0000_0042);
        send_txn(ACT_WRITE, SZ_BYTE, 32'hffff_7fff, 32'h0000_0042);
        send_txn(ACT_READ,  SZ_BYTE, 32'hfffe_ffff, 32'h0);
        random_burst(150);
    endtask

    // zero-sized regions: only the terminal and preload get through
    task automatic test_empty_regions();
        logic [31:0] base;
        base = $urandom;
        wait_bus_idle();
        set_config(base, 17'd0, base, 17'd0, 32'h0000_0000);
        send_txn(ACT_READ,    SZ_BYTE, base, 32'h0);
        send_txn(ACT_WRITE,   SZ_BYTE, base, 32'h0000_0077);
        send_txn(ACT_READ,    SZ_BYTE, 32'h0000_0000, 32'h0);
        send_txn(ACT_WRITE,   SZ_BYTE, 32'h0000_0001, 32'h0000_0077);
        send_txn(ACT_PRELOAD, SZ_BYTE, 32'h0000_0010, 32'h0000_0077);
        random_burst(100);
    endtask

    // RAM placed away from the memory region; stores still index from mem_base
    task automatic test_ram_outside_memory();
        wait_bus_idle();
        set_config(32'h2000_0000, 17'h0_1000, 32'h4000_0000, 17'h0_0100, 32'h2000_1000);
        random_burst(150);
    endtask

    task automatic test_random_configs();
        int phase;
        for (phase = 0; phase < 7; phase++) begin
            wait_bus_idle();
            random_config();
            random_burst(110);
        end
    endtask

    // back-to-back traffic with no gaps and no result stalls
    task automatic test_full_rate();
        wait_bus_idle();
        random_config();
        no_idle = 1'b1;
        random_burst(80);
        wait_bus_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MEM_BASE;
        i_cfg_wdata   <= 32'd0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_READ;
        i_access_size <= SZ_BYTE;
        i_address     <= 32'd0;
        i_write_data  <= 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_top_of_address_space();
        test_empty_regions();
        test_ram_outside_memory();
        test_random_configs();
        test_full_rate();

        wait_bus_idle();
        $display("covered %0d reads, %0d writes, %0d preloads, %0d ignored actions",
                 n_reads, n_writes, n_preloads, n_other);
        $display("under %0d region setups; %0d load faults, %0d store faults expected",
                 n_configs, n_load_faults, n_store_faults);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
